FILE: design/isr_pkg.sv
// shared types for the interval set block: operation codes and the
// controller to datapath command and status bundles
// no dependencies

package isr_pkg;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_UNION  = 3'd0,
    OP_INTER  = 3'd1,
    OP_DIFF   = 3'd2,
    OP_REVD   = 3'd3,
    OP_SYMD   = 3'd4,
    OP_QUERY  = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } op_e;

  // commands from the controller
  typedef struct packed {
    logic load;       // capture the input beat
    logic cnt_clr;    // return the word counter to zero
    logic cnt_inc;    // step the word counter
    logic clr_wr;     // write a zero word at the counter
    logic rd_sweep;   // read the word at the counter
    logic rd_query;   // read the word holding the query index
    logic q_capture;  // latch the query result
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic last_word;  // counter sits on the final word
  } status_t;

endpackage

FILE: design/interval_set_range_ops.sv
// interval set on a doubled grid: a range operation is busy through a sweep of WORDS
// bitmap words and a drain state, one word per cycle through the ram's read and write
// ports (WORDS = GRID_POINTS/32 rounded up for grids >= 32, 64 at the default), and
// takes no new beat until idle; a query is busy in its read and output states and its
// result beat strobes; after reset a clearing pass writes WORDS zero words with busy
// high; the receiver cannot stall; results are held in an output register

module interval_set_range_ops #(
  parameter int GRID_POINTS = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [9:0]  low_value_i,
  input  logic [9:0]  high_value_i,
  input  logic        low_open_i,
  input  logic        high_open_i,
  input  logic [10:0] query_index_i,
  output logic        result_valid_o,
  output logic        member_o,
  output logic [10:0] queried_index_o
);

  isr_pkg::cmd_t    cmd;
  isr_pkg::status_t status;

  // controller
  isr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // datapath
  isr_dp #(
    .GRID_POINTS (GRID_POINTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .operation_i     (operation_i),
    .low_value_i     (low_value_i),
    .high_value_i    (high_value_i),
    .low_open_i      (low_open_i),
    .high_open_i     (high_open_i),
    .query_index_i   (query_index_i),
    .result_valid_o  (result_valid_o),
    .member_o        (member_o),
    .queried_index_o (queried_index_o)
  );

endmodule

FILE: design/isr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module isr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/isr_ctrl.sv
// controller state machine for the interval set block
// depends on isr_pkg for operation codes and the command bundle

module isr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        operation_i,
  input  isr_pkg::status_t  status_i,
  output isr_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_QREAD = 6'b010000,
    ST_QOUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  isr_pkg::op_e op;

  assign op = isr_pkg::op_e'(operation_i);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.last_word) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          case (op) inside
            isr_pkg::OP_UNION, isr_pkg::OP_INTER, isr_pkg::OP_DIFF,
            isr_pkg::OP_REVD, isr_pkg::OP_SYMD: begin
              cmd_o.load    = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_SWEEP;
            end
            isr_pkg::OP_QUERY: begin
              cmd_o.load = 1'b1;
              state_d    = ST_QREAD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd_o.rd_sweep = 1'b1;
        if (status_i.last_word) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      ST_QREAD: begin
        cmd_o.rd_query = 1'b1;
        state_d        = ST_QOUT;
      end
      ST_QOUT: begin
        cmd_o.q_capture = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // a query beat leads straight to its read
  a_query_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i && op == isr_pkg::OP_QUERY) |=> (state_q == ST_QREAD))
    else $error("query did not start its read");

  // drain only follows the last sweep read
  a_drain_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> $past(state_q == ST_SWEEP && status_i.last_word))
    else $error("drain entered out of order");

endmodule

FILE: design/isr_dp.sv
// datapath for the interval set block: word counter, range mask,
// read-modify-write of the membership bitmap and the result registers
// depends on isr_pkg and isr_ram

module isr_dp #(
  parameter int GRID_POINTS = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isr_pkg::cmd_t    cmd_i,
  output isr_pkg::status_t status_o,
  input  logic [2:0]       operation_i,
  input  logic [9:0]       low_value_i,
  input  logic [9:0]       high_value_i,
  input  logic             low_open_i,
  input  logic             high_open_i,
  input  logic [10:0]      query_index_i,
  output logic             result_valid_o,
  output logic             member_o,
  output logic [10:0]      queried_index_o
);

  localparam int W     = (GRID_POINTS >= 32) ? 32 :
                         (GRID_POINTS >= 16) ? 16 :
                         (GRID_POINTS >= 8)  ? 8 : 4;
  localparam int WB    = $clog2(W);
  localparam int WORDS = (GRID_POINTS + W - 1) / W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = AW + WB;
  localparam int CW    = ((IW > 11) ? IW : 11) + 2;

  logic [AW-1:0]   cnt_q, wr_addr_q, rd_addr, wr_addr;
  logic            rd_vld_q;
  isr_pkg::op_e    op_q;
  logic [10:0]     a_q;
  logic [11:0]     b_q;
  logic [10:0]     qidx_q;
  logic [31:0]     qidx_ext, qword;
  logic            q_in_grid;
  logic [W-1:0]    rdata, mask, new_word, wdata;
  logic            we;
  logic            member_q, valid_q;
  logic [10:0]     qout_q;

  // word counter for the clear pass and the sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  assign status_o.last_word = (cnt_q == AW'(WORDS - 1));

  // read-to-write alignment of the sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= cnt_q;
  end

  // captured beat, endpoints mapped onto the doubled grid
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= isr_pkg::op_e'(operation_i);
      a_q    <= {low_value_i, 1'b0} + 11'(low_open_i);
      b_q    <= {1'b0, high_value_i, 1'b0} - 12'(high_open_i);
      qidx_q <= query_index_i;
    end
  end

  // query word address
  assign qidx_ext  = 32'(qidx_q);
  assign qword     = qidx_ext >> WB;
  assign q_in_grid = (qidx_ext < 32'(GRID_POINTS));

  assign rd_addr = cmd_i.rd_query ? qword[AW-1:0] : cnt_q;

  // interval mask over the word being written
  always_comb begin
    logic signed [CW-1:0] idx;
    mask = '0;
    for (int j = 0; j < W; j++) begin
      idx = $signed(CW'({wr_addr_q, WB'(j)}));
      mask[j] = (idx >= $signed(CW'(a_q))) &&
                (idx <= $signed({{(CW-12){b_q[11]}}, b_q})) &&
                (idx < $signed(CW'(GRID_POINTS)));
    end
  end

  // set operation on the word
  always_comb begin
    case (op_q)
      isr_pkg::OP_UNION: new_word = rdata | mask;
      isr_pkg::OP_INTER: new_word = rdata & mask;
      isr_pkg::OP_DIFF:  new_word = rdata & ~mask;
      isr_pkg::OP_REVD:  new_word = ~rdata & mask;
      isr_pkg::OP_SYMD:  new_word = rdata ^ mask;
      default:           new_word = rdata;
    endcase
  end

  // write port: clear pass or sweep write back
  assign we      = cmd_i.clr_wr | rd_vld_q;
  assign wr_addr = cmd_i.clr_wr ? cnt_q : wr_addr_q;
  assign wdata   = cmd_i.clr_wr ? '0 : new_word;

  isr_ram #(
    .Width (W),
    .Depth (WORDS),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // result beat registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.q_capture;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_capture) begin
      member_q <= q_in_grid & rdata[qidx_q[WB-1:0]];
      qout_q   <= qidx_q;
    end
  end

  assign result_valid_o  = valid_q;
  assign member_o        = member_q;
  assign queried_index_o = qout_q;

  // sweep write back never collides with the clear pass
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_vld_q && cmd_i.clr_wr))
    else $error("sweep write during clear pass");

  // a query read uses the port alone
  a_one_reader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_query && cmd_i.rd_sweep))
    else $error("two reads requested");

endmodule
